/* hdl/itt_pkg.sv */
// Package for the instance triangle transform block.
// Shared types, word indexes and fixed-point helpers; no dependencies.
package itt_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int NUM_WORDS = 10;

    localparam logic [3:0] IDX_TX = 4'd0;
    localparam logic [3:0] IDX_QX = 4'd3;
    localparam logic [3:0] IDX_QW = 4'd6;
    localparam logic [3:0] IDX_SX = 4'd7;

    localparam logic REQ_WORD = 1'b0;
    localparam logic REQ_VTX  = 1'b1;

    // queue entry between the front and the back end
    typedef struct packed {
        logic        is_vtx;
        logic [3:0]  word_index;
        logic [31:0] word_value;
        logic [31:0] vtx_x;
        logic [31:0] vtx_y;
        logic [31:0] vtx_z;
        logic        walkable;
    } itt_req_t;

    typedef logic signed [31:0] s32_t;

    // clamp a wide signed sum or product to the signed 32-bit range
    function automatic s32_t sat32(input logic signed [67:0] x);
        if (x > 68'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (x < -68'sh8000_0000) return 32'sh8000_0000;
        return x[31:0];
    endfunction

endpackage

/* hdl/itt_front.sv */
// Front end: two-entry request queue.
// Depends on itt_pkg.
module itt_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  itt_pkg::itt_req_t in_req,
    output logic              q_valid,
    input  logic              q_ready,
    output itt_pkg::itt_req_t q_req
);
    import itt_pkg::*;

    itt_req_t  mem_reg [2];
    logic      wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic      push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_req;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* hdl/itt_back.sv */
// Back end: sequenced transform datapath, triangle assembly, winding fix, output.
// Depends on itt_pkg. One multiplier reused over sequencer steps, two for normals.
module itt_back #(
    parameter int FRAC_BITS = itt_pkg::FRAC_BITS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  itt_pkg::itt_req_t q_req,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       out_x,
    output logic [31:0]       out_y,
    output logic [31:0]       out_z,
    output logic [1:0]        out_corner,
    output logic              out_last
);
    import itt_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_NRM  = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;

    // step numbers of the multiply sequence
    localparam logic [4:0] S_SCL = 5'd0;   // 0..2   v = loc*s
    localparam logic [4:0] S_T   = 5'd3;   // 3..8   q x v products
    localparam logic [4:0] S_C   = 5'd9;   // 9..14  q x t products
    localparam logic [4:0] S_W   = 5'd15;  // 15..17 w*t
    localparam logic [4:0] S_END = 5'd18;

    logic [2:0]  state_reg, state_next;
    logic [4:0]  step_reg;
    s32_t        tw_reg [NUM_WORDS];
    s32_t        loc_reg [3];
    s32_t        v_reg [3];
    s32_t        t_reg [3];
    s32_t        c_reg [3];
    logic signed [63:0] pa_reg;
    s32_t        wc_reg [9];
    logic [1:0]  cnt_reg;
    logic        walk_reg;
    logic        swap_reg;
    logic [1:0]  emit_reg;
    logic signed [63:0] prod_reg;
    logic signed [32:0] e1x, e1z, e2x, e2z;
    logic signed [65:0] nrm_a_reg, nrm_b_reg;
    logic        nrm_phase_reg;

    // multiplier operands selected by step
    s32_t mul_a, mul_b;
    logic signed [63:0] mul_p, mul_sh;
    logic [1:0] ci, cj, ck;
    logic [4:0] sub;

    // within a cross-product pair the first step takes operand j, the second
    // operand k, so each product only reads settled registers
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        sub   = '0;
        ci = 2'd0; cj = 2'd1; ck = 2'd2;
        if (step_reg < S_T) begin
            sub = step_reg - S_SCL;
            mul_a = loc_reg[sub[1:0]];
            mul_b = tw_reg[IDX_SX + {2'b0, sub[1:0]}];
        end else if (step_reg < S_C) begin
            sub = (step_reg - S_T) >> 1;
            ci = sub[1:0];
            cj = (ci == 2'd2) ? 2'd0 : ci + 2'd1;
            ck = (cj == 2'd2) ? 2'd0 : cj + 2'd1;
            if (!step_reg[0]) begin
                mul_a = tw_reg[IDX_QX + {2'b0, cj}]; mul_b = v_reg[ck];
            end else begin
                mul_a = tw_reg[IDX_QX + {2'b0, ck}]; mul_b = v_reg[cj];
            end
        end else if (step_reg < S_W) begin
            sub = (step_reg - S_C) >> 1;
            ci = sub[1:0];
            cj = (ci == 2'd2) ? 2'd0 : ci + 2'd1;
            ck = (cj == 2'd2) ? 2'd0 : cj + 2'd1;
            if (!step_reg[0]) begin
                mul_a = tw_reg[IDX_QX + {2'b0, cj}]; mul_b = t_reg[ck];
            end else begin
                mul_a = tw_reg[IDX_QX + {2'b0, ck}]; mul_b = t_reg[cj];
            end
        end else begin
            sub = step_reg - S_W;
            ci = sub[1:0];
            mul_a = tw_reg[IDX_QW];
            mul_b = t_reg[ci];
        end
        mul_p  = 64'(mul_a) * 64'(mul_b);
        mul_sh = mul_p >>> FRAC_BITS;
    end

    assign e1x = 33'(wc_reg[3]) - 33'(wc_reg[0]);
    assign e1z = 33'(wc_reg[5]) - 33'(wc_reg[2]);
    assign e2x = 33'(wc_reg[6]) - 33'(wc_reg[0]);
    assign e2z = 33'(wc_reg[8]) - 33'(wc_reg[2]);

    logic [1:0] src;
    logic [3:0] base;
    always_comb begin
        src = emit_reg;
        if (swap_reg && emit_reg == 2'd1) src = 2'd2;
        if (swap_reg && emit_reg == 2'd2) src = 2'd1;
        base = {2'b0, src} + {1'b0, src, 1'b0};
    end

    assign out_valid  = (state_reg == ST_EMIT);
    assign out_x      = wc_reg[base];
    assign out_y      = wc_reg[base + 4'd1];
    assign out_z      = wc_reg[base + 4'd2];
    assign out_corner = emit_reg;
    assign out_last   = (emit_reg == 2'd2);
    assign q_ready    = (state_reg == ST_IDLE);

    // prod_reg holds the registered product: step index of the result in prod_reg
    logic [4:0] pstep;
    assign pstep = step_reg - 5'd1;
    logic [1:0] pi;
    logic [4:0] psub;
    logic [3:0] wbase;
    always_comb begin
        psub = '0;
        if (pstep < S_T) psub = pstep;
        else if (pstep < S_C) psub = (pstep - S_T) >> 1;
        else if (pstep < S_W) psub = (pstep - S_C) >> 1;
        else psub = pstep - S_W;
        pi = psub[1:0];
        wbase = {2'b0, cnt_reg} + {1'b0, cnt_reg, 1'b0};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_valid && q_req.is_vtx) state_next = ST_MUL;
            ST_MUL:  if (step_reg == S_END)
                         state_next = (cnt_reg == 2'd2) ? ST_NRM : ST_IDLE;
            ST_NRM:  if (nrm_phase_reg) state_next = ST_EMIT;
            ST_EMIT: if (out_ready && emit_reg == 2'd2) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_sh;
        case (state_reg)
            ST_IDLE: begin
                step_reg <= S_SCL;
                if (q_valid && q_req.is_vtx) begin
                    loc_reg[0] <= q_req.vtx_x;
                    loc_reg[1] <= q_req.vtx_y;
                    loc_reg[2] <= q_req.vtx_z;
                    walk_reg   <= q_req.walkable;
                end
            end
            ST_MUL: begin
                step_reg <= step_reg + 5'd1;
                if (step_reg != S_SCL) begin
                    if (pstep < S_T) begin
                        v_reg[pi] <= sat32(68'(prod_reg));
                    end else if (pstep < S_C) begin
                        // odd step: subtrahend q_k*v_j, even step: q_j*v_k
                        if (pstep[0]) pa_reg <= prod_reg;
                        else t_reg[pi] <= sat32((68'(prod_reg) - 68'(pa_reg)) <<< 1);
                    end else if (pstep < S_W) begin
                        if (pstep[0]) pa_reg <= prod_reg;
                        else c_reg[pi] <= sat32(68'(prod_reg) - 68'(pa_reg));
                    end else begin
                        wc_reg[wbase + {2'b0, pi}] <= sat32(68'(v_reg[pi]) + 68'(prod_reg)
                            + 68'(c_reg[pi]) + 68'(tw_reg[IDX_TX + {2'b0, pi}]));
                    end
                end
            end
            ST_NRM: begin
                if (!nrm_phase_reg) begin
                    nrm_a_reg <= 66'(e1z) * 66'(e2x);
                    nrm_b_reg <= 66'(e1x) * 66'(e2z);
                end else begin
                    swap_reg <= walk_reg && (nrm_a_reg < nrm_b_reg);
                end
            end
            default: ;
        endcase
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 2'd0;
            emit_reg      <= 2'd0;
            nrm_phase_reg <= 1'b0;
            swap_reg      <= 1'b0;
            for (int i = 0; i < NUM_WORDS; i++) tw_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && q_valid && !q_req.is_vtx &&
                q_req.word_index < 4'(NUM_WORDS))
                tw_reg[q_req.word_index] <= q_req.word_value;
            if (state_reg == ST_MUL && step_reg == S_END && cnt_reg != 2'd2)
                cnt_reg <= cnt_reg + 2'd1;
            if (state_reg == ST_NRM) nrm_phase_reg <= ~nrm_phase_reg;
            if (state_reg == ST_EMIT && out_ready) begin
                emit_reg <= (emit_reg == 2'd2) ? 2'd0 : emit_reg + 2'd1;
                if (emit_reg == 2'd2) cnt_reg <= 2'd0;
            end
        end
    end

endmodule

/* hdl/instance_triangle_transform_winding.sv */
// Top level of the instance triangle transform with winding correction.
// Depends on itt_pkg, itt_front, itt_back.
//
//  channel | direction | tdata fields (low bit up)                     | tuser (low up)
//  s_      | in        | word_index, word_value, vtx_x, vtx_y, vtx_z,  | type, walkable
//          |           |   pad to 136 bits                             |
//  m_      | out       | out_x, out_y, out_z, corner, pad to 104 bits  | -  (tlast: last)
//
// A word load is taken while the back end is idle; a vertex is dispatched from the
// idle state and then runs the sequencer steps on the shared 32x32 multiplier
// (scale, two cross products, w*t, sums).
// The third vertex adds the normal products and compare, and three output transfers.
// The two-entry queue lets the input take up to two transfers while results stall.
// Reset is synchronous, active low; it clears the transform words and counts.
module instance_triangle_transform_winding #(
    parameter int FRAC_BITS = itt_pkg::FRAC_BITS_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // word_index[3:0], word_value, vtx_x, vtx_y, vtx_z
    input  logic [1:0]   s_tuser,   // req_type, walkable
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // out_x, out_y, out_z, corner[1:0]
    output logic         m_tlast    // last
);
    import itt_pkg::*;

    itt_req_t in_req, q_req;
    logic q_valid, q_ready;
    logic [31:0] ox, oy, oz;
    logic [1:0]  oc;

    assign in_req.is_vtx     = s_tuser[0];
    assign in_req.word_index = s_tdata[3:0];
    assign in_req.word_value = s_tdata[35:4];
    assign in_req.vtx_x      = s_tdata[67:36];
    assign in_req.vtx_y      = s_tdata[99:68];
    assign in_req.vtx_z      = s_tdata[131:100];
    assign in_req.walkable   = s_tuser[1];

    itt_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_req,
        .q_valid, .q_ready, .q_req
    );

    itt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk, .aresetn,
        .q_valid, .q_ready, .q_req,
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_x(ox), .out_y(oy), .out_z(oz), .out_corner(oc), .out_last(m_tlast)
    );

    assign m_tdata = {6'b0, oc, oz, oy, ox};

    // last marks exactly the third corner
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[97:96] == 2'd2)))
        else $error("last/corner mismatch");
    // corner advances only after an output transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata[97:96]))
        else $error("corner moved while stalled");

endmodule

/* test/testbench.sv */
// Testbench for instance_triangle_transform_winding: stream stimulus, in-bench predictor,
// scoreboard class comparing every output transfer. Depends on itt_pkg and the top level.
module testbench;
    import itt_pkg::*;

    localparam int FRAC = FRAC_BITS_DEFAULT;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [31:0] x, y, z;
        logic [1:0]  corner;
        logic        last;
    } world_corner_t;

    // Transform predictor plus the queue of world corners still owed by the block.
    class triangle_scoreboard;
        longint        xform[NUM_WORDS];
        longint        corners[9];
        int            corner_cnt;
        world_corner_t owed[$];
        int            errors;

        function new();
            foreach (xform[i]) xform[i] = 0;
            foreach (corners[i]) corners[i] = 0;
            corner_cnt = 0;
            errors = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // exact product, floor shift by the fraction width
        function longint fmul(longint a, longint b);
            return (a * b) >>> FRAC;
        endfunction

        function void place_corner(longint lx, longint ly, longint lz, int slot);
            longint loc[3], v[3], t[3], c[3];
            int j, k;
            loc[0] = lx; loc[1] = ly; loc[2] = lz;
            for (int i = 0; i < 3; i++) v[i] = clamp32(fmul(loc[i], xform[IDX_SX + i]));
            for (int i = 0; i < 3; i++) begin
                j = (i + 1) % 3; k = (i + 2) % 3;
                t[i] = clamp32(2 * (fmul(xform[IDX_QX + j], v[k])
                                  - fmul(xform[IDX_QX + k], v[j])));
            end
            for (int i = 0; i < 3; i++) begin
                j = (i + 1) % 3; k = (i + 2) % 3;
                c[i] = clamp32(fmul(xform[IDX_QX + j], t[k]) - fmul(xform[IDX_QX + k], t[j]));
            end
            for (int i = 0; i < 3; i++)
                corners[slot * 3 + i] = clamp32(v[i] + fmul(xform[IDX_QW], t[i]) + c[i]
                                                + xform[IDX_TX + i]);
        endfunction

        // Y of (c1-c0) x (c2-c0), exact
        function bit normal_y_neg();
            logic signed [127:0] e1x, e1z, e2x, e2z, ny;
            e1x = corners[3] - corners[0];
            e1z = corners[5] - corners[2];
            e2x = corners[6] - corners[0];
            e2z = corners[8] - corners[2];
            ny = e1z * e2x - e1x * e2z;
            return ny < 0;
        endfunction

        function void note_input(logic req, logic [3:0] idx, logic [31:0] wval,
                                 logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                 logic walk);
            int order[3];
            world_corner_t wc;
            if (req == REQ_WORD) begin
                if (idx < NUM_WORDS) xform[idx] = longint'($signed(wval));
                return;
            end
            place_corner(longint'($signed(vx)), longint'($signed(vy)),
                         longint'($signed(vz)), corner_cnt);
            if (corner_cnt < 2) begin
                corner_cnt++;
                return;
            end
            corner_cnt = 0;
            order = '{0, 1, 2};
            if (walk && normal_y_neg()) order = '{0, 2, 1};
            for (int n = 0; n < 3; n++) begin
                wc.x = corners[order[n] * 3][31:0];
                wc.y = corners[order[n] * 3 + 1][31:0];
                wc.z = corners[order[n] * 3 + 2][31:0];
                wc.corner = n[1:0];
                wc.last = (n == 2);
                owed.insert(owed.size(), wc);
            end
        endfunction

        function void check_result(logic [103:0] data, logic last);
            world_corner_t e;
            if (owed.size() == 0) begin
                $display("%0t: unexpected output transfer data=%h last=%b", $time, data, last);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (data[31:0] !== e.x) begin
                $display("%0t: out_x expected %h actual %h", $time, e.x, data[31:0]);
                errors++;
            end
            if (data[63:32] !== e.y) begin
                $display("%0t: out_y expected %h actual %h", $time, e.y, data[63:32]);
                errors++;
            end
            if (data[95:64] !== e.z) begin
                $display("%0t: out_z expected %h actual %h", $time, e.z, data[95:64]);
                errors++;
            end
            if (data[97:96] !== e.corner) begin
                $display("%0t: corner expected %0d actual %0d", $time, e.corner, data[97:96]);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: last expected %b actual %b", $time, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         m_tlast;

    triangle_scoreboard sb = new();
    int idle_pct  = 0;   // sender idle chance, percent
    int stall_pct = 0;   // receiver stall chance, percent
    int quiet_cycles = 0;

    instance_triangle_transform_winding i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // receiver: random backpressure per current phase
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // output monitor; m_tready read here is the value seen by the edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one input transfer with optional leading idle cycles; valid stays up
    // between back-to-back transfers
    task automatic push(logic req, logic [3:0] idx, logic [31:0] wval,
                        logic [31:0] vx, logic [31:0] vy, logic [31:0] vz, logic walk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {walk, req};
        s_tdata  <= {4'b0, vz, vy, vx, wval, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(req, idx, wval, vx, vy, vz, walk);
    endtask

    // loads carry junk in the unused vertex fields, vertices junk in the word fields
    task automatic load_word(logic [3:0] idx, logic [31:0] val);
        push(REQ_WORD, idx, val, $urandom, $urandom, $urandom, 1'($urandom_range(1)));
    endtask

    task automatic vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz, logic walk);
        push(REQ_VTX, 4'($urandom_range(15)), $urandom, vx, vy, vz, walk);
    endtask

    // Q16.16 value with raw magnitude up to about 2^range_bits, centered on zero
    function automatic logic [31:0] rand_q(int range_bits);
        logic [31:0] r;
        r = $urandom;
        return $signed(r) >>> (31 - range_bits);
    endfunction

    task automatic random_transform();
        for (int i = 0; i < 3; i++) load_word(4'(IDX_TX + i), rand_q(24));
        for (int i = 0; i < 4; i++) load_word(4'(IDX_QX + i), rand_q(16));
        for (int i = 0; i < 3; i++) load_word(4'(IDX_SX + i), rand_q(18));
    endtask

    task automatic random_triangle();
        for (int n = 0; n < 3; n++)
            vertex(rand_q(22), rand_q(22), rand_q(22), 1'($urandom_range(1)));
    endtask

    initial begin
        int sent;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 2'b0;
        m_tready = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: all-zero transform collapses everything to the origin
        vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b1);
        vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0);
        vertex(32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1);
        // identity rotation, unit scale; out-of-range index is dropped
        load_word(IDX_QW, 32'h0001_0000);
        load_word(IDX_SX, 32'h0001_0000);
        load_word(IDX_SX + 4'd1, 32'h0001_0000);
        load_word(IDX_SX + 4'd2, 32'h0001_0000);
        load_word(4'd15, 32'hDEAD_BEEF);
        load_word(4'd10, 32'h8000_0000);
        // walkable, normal Y negative: corners 1 and 2 swap
        vertex(32'h0, 32'h0, 32'h0, 1'b0);
        vertex(32'h0001_0000, 32'h0, 32'h0, 1'b0);
        vertex(32'h0, 32'h0, 32'h0001_0000, 1'b1);
        // same winding reversed: order kept
        vertex(32'h0, 32'h0, 32'h0, 1'b1);
        vertex(32'h0, 32'h0, 32'h0001_0000, 1'b1);
        vertex(32'h0001_0000, 32'h0, 32'h0, 1'b1);
        // translation load mid-triangle saturates x: normal Y negative, corners swap
        vertex(32'h0, 32'h0, 32'h0, 1'b0);
        load_word(IDX_TX, 32'h7FFF_FFFF);
        vertex(32'h0002_0000, 32'h0, 32'h0002_0000, 1'b0);
        vertex(32'h0004_0000, 32'h5, 32'h0004_0000, 1'b1);
        // saturation: max x scale, most negative qx, max x translation with extreme corners
        load_word(IDX_SX, 32'h7FFF_FFFF);
        load_word(IDX_QX, 32'h8000_0000);
        vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        vertex(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        vertex(32'hFFFF_FFFF, 32'h0, 32'h1, 1'b1);

        // random: mostly triangles, with occasional fresh transforms and some noise
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 48; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 48; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            sent = 0;
            while (sent < 45) begin
                case ($urandom_range(9))
                    0: begin
                        random_transform();
                        sent += 10;
                    end
                    1: begin
                        // raw noise over every bit of every field
                        push(1'($urandom_range(1)), 4'($urandom_range(15)), $urandom,
                             $urandom, $urandom, $urandom, 1'($urandom_range(1)));
                        sent++;
                    end
                    2: begin
                        load_word(4'($urandom_range(15)), $urandom);
                        sent++;
                    end
                    default: begin
                        random_triangle();
                        sent += 3;
                    end
                endcase
            end
        end
        s_tvalid <= 1'b0;

        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
